// ===== rtl/core/sorted_score_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted score table core.
// Clocked property checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SORTED_SCORE_TABLE_CORE_ASSERT_SVH
`define SORTED_SCORE_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define SST_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sst: assertion failed");

// The expression must never be true at a rising edge outside reset.
`define SST_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sst: forbidden condition seen");

`else

`define SST_ASSERT(name, clk, rst_n, prop)
`define SST_NEVER(name, clk, rst_n, expr)

`endif

`endif

// ===== rtl/core/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int OP_W     = 3;
    localparam int TAG_W    = 32;
    localparam int SCORE_W  = 16;
    localparam int STATUS_W = 3;

    localparam int IN_FIELD_W  = OP_W + TAG_W + SCORE_W;
    localparam int OUT_FIELD_W = STATUS_W + TAG_W + SCORE_W;
    localparam int S_DATA_W    = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_LIST_ASC = 3'd2,
        OP_LIST_DSC = 3'd3,
        OP_LOWEST   = 3'd4,
        OP_SAME     = 3'd5,
        OP_BACKWARD = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENTRY    = 3'd0,
        ST_ADDED    = 3'd1,
        ST_DELETED  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_NOMATCH  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_LIST
    } state_t;

    typedef enum logic [2:0] {
        SEL_TABLE,
        SEL_LOWEST,
        SEL_FIRST,
        SEL_ECHO,
        SEL_ZERO
    } emit_sel_t;

    typedef enum logic [1:0] {
        WALK_ASC,
        WALK_DESC,
        WALK_MATCH,
        WALK_BACK
    } walk_t;

    typedef struct packed {
        logic      load;
        logic      scan;
        logic      do_insert;
        logic      do_delete;
        logic      emit;
        emit_sel_t emit_sel;
        status_t   emit_status;
        logic      emit_last;
        logic      walk_init;
        walk_t     walk_mode;
        logic      walk_step;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            found;
        logic            score_hit;
        logic            walk_hit;
        logic            walk_last;
        logic            out_free;
    } sts_t;

endpackage

// ===== rtl/core/sst_ctrl.sv =====
// ----------------------------------------------------------------------------
// sst_ctrl
// Request sequencer: accepts a request, orders the datapath through its
// compare, update and listing steps, and paces results against the output.
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  sst_pkg::sts_t sts,
    output sst_pkg::cmd_t cmd
);

    sst_pkg::state_t state_reg;
    sst_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sst_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == sst_pkg::S_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_sel    = sst_pkg::SEL_ZERO;
        cmd.emit_status = sst_pkg::ST_ENTRY;
        cmd.walk_mode   = sst_pkg::WALK_ASC;

        unique case (state_reg)
            sst_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sst_pkg::S_SCAN;
                end
            end

            sst_pkg::S_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = sst_pkg::S_ACT;
            end

            sst_pkg::S_ACT: begin
                if (sts.out_free) begin
                    state_next = sst_pkg::S_IDLE;
                    priority if (sts.op == sst_pkg::OP_INSERT) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = sst_pkg::SEL_ECHO;
                        cmd.emit_last = 1'b1;
                        if (sts.full) begin
                            cmd.emit_status = sst_pkg::ST_NOMATCH;
                        end else begin
                            cmd.do_insert   = 1'b1;
                            cmd.emit_status = sst_pkg::ST_ADDED;
                        end
                    end else if (sts.op > sst_pkg::OP_BACKWARD) begin
                        // Undefined operation code: dropped without a result.
                        state_next = sst_pkg::S_IDLE;
                    end else if (sts.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = sst_pkg::ST_EMPTY;
                        cmd.emit_last   = 1'b1;
                    end else begin
                        unique case (sts.op)
                            sst_pkg::OP_DELETE: begin
                                cmd.emit      = 1'b1;
                                cmd.emit_last = 1'b1;
                                if (sts.found) begin
                                    cmd.do_delete   = 1'b1;
                                    cmd.emit_sel    = sst_pkg::SEL_FIRST;
                                    cmd.emit_status = sst_pkg::ST_DELETED;
                                end else begin
                                    cmd.emit_status = sst_pkg::ST_NOTFOUND;
                                end
                            end
                            sst_pkg::OP_LIST_ASC: begin
                                cmd.walk_init = 1'b1;
                                cmd.walk_mode = sst_pkg::WALK_ASC;
                                state_next    = sst_pkg::S_LIST;
                            end
                            sst_pkg::OP_LIST_DSC: begin
                                cmd.walk_init = 1'b1;
                                cmd.walk_mode = sst_pkg::WALK_DESC;
                                state_next    = sst_pkg::S_LIST;
                            end
                            sst_pkg::OP_LOWEST: begin
                                cmd.emit      = 1'b1;
                                cmd.emit_sel  = sst_pkg::SEL_LOWEST;
                                cmd.emit_last = 1'b1;
                            end
                            sst_pkg::OP_SAME: begin
                                if (sts.score_hit) begin
                                    cmd.walk_init = 1'b1;
                                    cmd.walk_mode = sst_pkg::WALK_MATCH;
                                    state_next    = sst_pkg::S_LIST;
                                end else begin
                                    cmd.emit        = 1'b1;
                                    cmd.emit_status = sst_pkg::ST_NOMATCH;
                                    cmd.emit_last   = 1'b1;
                                end
                            end
                            sst_pkg::OP_BACKWARD: begin
                                if (sts.found) begin
                                    cmd.walk_init = 1'b1;
                                    cmd.walk_mode = sst_pkg::WALK_BACK;
                                    state_next    = sst_pkg::S_LIST;
                                end else begin
                                    cmd.emit        = 1'b1;
                                    cmd.emit_status = sst_pkg::ST_NOTFOUND;
                                    cmd.emit_last   = 1'b1;
                                end
                            end
                            default: begin
                                state_next = sst_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end

            sst_pkg::S_LIST: begin
                if (!sts.walk_hit) begin
                    cmd.walk_step = 1'b1;
                end else if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = sst_pkg::SEL_TABLE;
                    cmd.emit_last = sts.walk_last;
                    if (sts.walk_last) begin
                        state_next = sst_pkg::S_IDLE;
                    end else begin
                        cmd.walk_step = 1'b1;
                    end
                end
            end

            default: begin
                state_next = sst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/sst_dp.sv =====
// ----------------------------------------------------------------------------
// sst_dp
// Datapath: request register, shifting entry table, per-slot compare masks,
// listing walker and the output register of the result channel.
// ----------------------------------------------------------------------------
`include "sorted_score_table_core_assert.svh"

module sst_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [sst_pkg::S_DATA_W-1:0]   s_tdata,
    input  sst_pkg::cmd_t                  cmd,
    output sst_pkg::sts_t                  sts,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sst_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast
);

    // Request register.
    logic [sst_pkg::OP_W-1:0]    op_reg;
    logic [sst_pkg::TAG_W-1:0]   tag_reg;
    logic [sst_pkg::SCORE_W-1:0] score_reg;

    // Entry table, held in ascending score order in slots below count_reg.
    logic [sst_pkg::TAG_W-1:0]   tag_tab_reg   [sst_pkg::TABLE_DEPTH];
    logic [sst_pkg::SCORE_W-1:0] score_tab_reg [sst_pkg::TABLE_DEPTH];
    logic [sst_pkg::TAG_W-1:0]   tag_tab_next  [sst_pkg::TABLE_DEPTH];
    logic [sst_pkg::SCORE_W-1:0] score_tab_next[sst_pkg::TABLE_DEPTH];
    logic [sst_pkg::CNT_W-1:0]   count_reg;
    logic [sst_pkg::CNT_W-1:0]   count_next;

    // Compare masks, one bit per slot.
    logic [sst_pkg::TABLE_DEPTH-1:0] le_mask_reg;
    logic [sst_pkg::TABLE_DEPTH-1:0] teq_mask_reg;
    logic [sst_pkg::TABLE_DEPTH-1:0] seq_mask_reg;
    logic [sst_pkg::TABLE_DEPTH-1:0] le_mask_next;
    logic [sst_pkg::TABLE_DEPTH-1:0] teq_mask_next;
    logic [sst_pkg::TABLE_DEPTH-1:0] seq_mask_next;
    logic [sst_pkg::TABLE_DEPTH-1:0] le_prev;
    logic [sst_pkg::TABLE_DEPTH-1:0] first_hot;
    logic [sst_pkg::TABLE_DEPTH-1:0] shift_sel;
    logic [sst_pkg::IDX_W-1:0]       first_idx;

    // Listing walker.
    logic [sst_pkg::IDX_W-1:0] idx_reg;
    logic [sst_pkg::IDX_W-1:0] idx_next;
    logic                      down_reg;
    logic                      down_next;
    logic                      filter_reg;
    logic                      filter_next;
    logic [sst_pkg::IDX_W-1:0] top_idx;

    // Output register.
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [sst_pkg::STATUS_W-1:0]  out_status_reg;
    logic [sst_pkg::TAG_W-1:0]     out_name_reg;
    logic [sst_pkg::SCORE_W-1:0]   out_score_reg;
    logic                          out_last_reg;
    logic [sst_pkg::TAG_W-1:0]     sel_tag;
    logic [sst_pkg::SCORE_W-1:0]   sel_score;
    logic [sst_pkg::TAG_W-1:0]     first_tag;
    logic [sst_pkg::SCORE_W-1:0]   first_score;
    logic                          out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign top_idx  = sst_pkg::IDX_W'(count_reg - sst_pkg::CNT_W'(1));

    // ------------------------------------------------------------------
    // Request register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_tdata[sst_pkg::OP_W-1:0];
            tag_reg   <= s_tdata[sst_pkg::OP_W +: sst_pkg::TAG_W];
            score_reg <= s_tdata[sst_pkg::OP_W + sst_pkg::TAG_W +: sst_pkg::SCORE_W];
        end
    end

    // ------------------------------------------------------------------
    // Slot compares
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < sst_pkg::TABLE_DEPTH; i++) begin
            if (sst_pkg::CNT_W'(i) < count_reg) begin
                le_mask_next[i]  = $signed(score_tab_reg[i]) <= $signed(score_reg);
                teq_mask_next[i] = (tag_tab_reg[i] == tag_reg);
                seq_mask_next[i] = (score_tab_reg[i] == score_reg);
            end else begin
                le_mask_next[i]  = 1'b0;
                teq_mask_next[i] = 1'b0;
                seq_mask_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            le_mask_reg  <= le_mask_next;
            teq_mask_reg <= teq_mask_next;
            seq_mask_reg <= seq_mask_next;
        end
    end

    // Lowest matching tag, and every slot from it upward.
    assign first_hot = teq_mask_reg & (~teq_mask_reg + sst_pkg::TABLE_DEPTH'(1));
    assign shift_sel = ~(first_hot - sst_pkg::TABLE_DEPTH'(1)) & {sst_pkg::TABLE_DEPTH{|first_hot}};
    assign le_prev   = {le_mask_reg[sst_pkg::TABLE_DEPTH-2:0], 1'b1};

    always_comb begin
        first_idx   = '0;
        first_tag   = '0;
        first_score = '0;
        for (int i = 0; i < sst_pkg::TABLE_DEPTH; i++) begin
            first_idx   = first_idx | (sst_pkg::IDX_W'(i) & {sst_pkg::IDX_W{first_hot[i]}});
            first_tag   = first_tag | (tag_tab_reg[i] & {sst_pkg::TAG_W{first_hot[i]}});
            first_score = first_score
                        | (score_tab_reg[i] & {sst_pkg::SCORE_W{first_hot[i]}});
        end
    end

    // ------------------------------------------------------------------
    // Table update: insert opens a gap above the last equal-or-lower score,
    // delete closes the gap at the first matching tag.
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < sst_pkg::TABLE_DEPTH; i++) begin
            tag_tab_next[i]   = tag_tab_reg[i];
            score_tab_next[i] = score_tab_reg[i];
            if (cmd.do_insert && !le_mask_reg[i] && le_prev[i]) begin
                tag_tab_next[i]   = tag_reg;
                score_tab_next[i] = score_reg;
            end
        end
        for (int i = 1; i < sst_pkg::TABLE_DEPTH; i++) begin
            if (cmd.do_insert && !le_mask_reg[i] && !le_prev[i]) begin
                tag_tab_next[i]   = tag_tab_reg[i-1];
                score_tab_next[i] = score_tab_reg[i-1];
            end
        end
        for (int i = 0; i < sst_pkg::TABLE_DEPTH - 1; i++) begin
            if (cmd.do_delete && shift_sel[i]) begin
                tag_tab_next[i]   = tag_tab_reg[i+1];
                score_tab_next[i] = score_tab_reg[i+1];
            end
        end

        count_next = count_reg;
        if (cmd.do_insert) begin
            count_next = count_reg + sst_pkg::CNT_W'(1);
        end else if (cmd.do_delete) begin
            count_next = count_reg - sst_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < sst_pkg::TABLE_DEPTH; i++) begin
            tag_tab_reg[i]   <= tag_tab_next[i];
            score_tab_reg[i] <= score_tab_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Listing walker
    // ------------------------------------------------------------------
    always_comb begin
        idx_next    = idx_reg;
        down_next   = down_reg;
        filter_next = filter_reg;
        if (cmd.walk_init) begin
            unique case (cmd.walk_mode)
                sst_pkg::WALK_ASC: begin
                    idx_next    = '0;
                    down_next   = 1'b0;
                    filter_next = 1'b0;
                end
                sst_pkg::WALK_DESC: begin
                    idx_next    = top_idx;
                    down_next   = 1'b1;
                    filter_next = 1'b0;
                end
                sst_pkg::WALK_MATCH: begin
                    idx_next    = '0;
                    down_next   = 1'b0;
                    filter_next = 1'b1;
                end
                sst_pkg::WALK_BACK: begin
                    idx_next    = first_idx;
                    down_next   = 1'b1;
                    filter_next = 1'b0;
                end
                default: begin
                    idx_next = '0;
                end
            endcase
        end else if (cmd.walk_step) begin
            idx_next = down_reg ? idx_reg - sst_pkg::IDX_W'(1)
                                : idx_reg + sst_pkg::IDX_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        unique case (cmd.emit_sel)
            sst_pkg::SEL_TABLE: begin
                sel_tag   = tag_tab_reg[idx_reg];
                sel_score = score_tab_reg[idx_reg];
            end
            sst_pkg::SEL_LOWEST: begin
                sel_tag   = tag_tab_reg[0];
                sel_score = score_tab_reg[0];
            end
            sst_pkg::SEL_FIRST: begin
                sel_tag   = first_tag;
                sel_score = first_score;
            end
            sst_pkg::SEL_ECHO: begin
                sel_tag   = tag_reg;
                sel_score = score_reg;
            end
            default: begin
                sel_tag   = '0;
                sel_score = '0;
            end
        endcase

        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg <= cmd.emit_status;
            out_name_reg   <= sel_tag;
            out_score_reg  <= sel_score;
            out_last_reg   <= cmd.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
            down_reg     <= 1'b0;
            filter_reg   <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
            down_reg     <= down_next;
            filter_reg   <= filter_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = sst_pkg::M_DATA_W'({out_score_reg, out_name_reg, out_status_reg});

    // ------------------------------------------------------------------
    // Status to the controller
    // ------------------------------------------------------------------
    always_comb begin
        sts.op        = op_reg;
        sts.empty     = (count_reg == '0);
        sts.full      = (count_reg == sst_pkg::CNT_W'(sst_pkg::TABLE_DEPTH));
        sts.found     = |teq_mask_reg;
        sts.score_hit = |seq_mask_reg;
        sts.walk_hit  = filter_reg ? seq_mask_reg[idx_reg] : 1'b1;
        if (down_reg) begin
            sts.walk_last = (idx_reg == '0);
        end else if (filter_reg) begin
            sts.walk_last = ~|((seq_mask_reg >> idx_reg) >> 1);
        end else begin
            sts.walk_last = (idx_reg == top_idx);
        end
        sts.out_free  = out_free;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SST_ASSERT(a_count_bound, aclk, aresetn, count_reg <= sst_pkg::CNT_W'(sst_pkg::TABLE_DEPTH))
    `SST_ASSERT(a_insert_grows, aclk, aresetn, cmd.do_insert |=> count_reg == $past(count_reg) + sst_pkg::CNT_W'(1))
    `SST_NEVER(a_emit_overrun, aclk, aresetn, cmd.emit && !out_free)
    `SST_NEVER(a_delete_empty, aclk, aresetn, cmd.do_delete && (count_reg == '0))

endmodule

// ===== rtl/core/sorted_score_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_score_table_core
// Bounded table of (name tag, score) entries kept in ascending score order.
// ----------------------------------------------------------------------------
// Usage: a request enters on the s_ channel (operation, name tag, score) and
// gives one or more results on the m_ channel; m_tlast marks the final result
// of each request. Operations are insert, delete by tag, list ascending, list
// descending, report lowest, list all entries of one score, and list backward
// from a named entry. Empty table, tag not found, no score match and full
// table each give a single status result. An undefined operation code is
// consumed and gives no result.
// Timing: a request is taken only while the block is idle. It passes through
// the accept, per-slot compare and update or first-result steps in that
// order. Listings then give one result per cycle while the receiver takes
// them; the same-score listing steps through every slot from the lowest up
// to its last match, one slot a cycle unless a match waits on the receiver.
// The slot walk is what sets a listing's length.
// Reset empties the table; entry contents need no clearing since slots at or
// above the entry count never reach a result. A stalled receiver holds the
// result in the output register and the sequencer waits, losing nothing.
// ----------------------------------------------------------------------------
module sorted_score_table_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Request channel. s_tdata, low bit up: operation[2:0], name_tag[34:3],
    // score_value[50:35], zero fill[55:51].
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sst_pkg::S_DATA_W-1:0] s_tdata,
    // Result channel. m_tdata, low bit up: status[2:0], entry_name[34:3],
    // entry_score[50:35], zero fill[55:51]. m_tlast ends one request.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sst_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);

    // Commands from the sequencer and status back from the datapath.
    sst_pkg::cmd_t cmd;
    sst_pkg::sts_t sts;

    // The sequencer owns s_tready: a transfer on the request channel happens
    // only in its idle state, and it issues the register load in that cycle.
    sst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the table and drives the result channel from its
    // output register.
    sst_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
